FILE: rtl/matrix3x3_inverse_assert.svh
// Assertion macros used by the matrix inverse checker.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MINV_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("matrix inverse check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MINV_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("matrix inverse check failed");

`endif

FILE: rtl/minv_pkg.sv
// Shared constants for the 3x3 matrix inverse pipeline.
// No dependencies; every module imports this package.
`default_nettype none

package minv_pkg;

	// Default element width (Q4.12).
	localparam int ELEM_W_DEF = 16;
	// Width of each element field on the stream buses.
	localparam int FIELD_W = 16;
	// Elements per matrix.
	localparam int N_ELEM = 9;
	// Width of the determinant field on the result bus.
	localparam int DET_OUT_W = 49;
	// Bus widths.
	localparam int IN_DATA_W = N_ELEM * FIELD_W;
	localparam int OUT_DATA_W = ((N_ELEM * FIELD_W + DET_OUT_W + 7) / 8) * 8;
	localparam int USER_W = 2;
	// Bit positions in the result tuser.
	localparam int USER_SINGULAR = 0;
	localparam int USER_CLIPPED = 1;

endpackage

`default_nettype wire

FILE: rtl/minv_adj.sv
// Cofactor and determinant stages (four register stages) of the inverse pipeline.
// Depends on minv_pkg.
`default_nettype none

module minv_adj import minv_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_W_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [ELEM_WIDTH-1:0]        a_s1 [N_ELEM],
	output logic signed [ELEM_WIDTH-1:0]        a_s5 [N_ELEM],
	output logic signed [2*ELEM_WIDTH:0]        co_s5 [N_ELEM],
	output logic signed [3*ELEM_WIDTH:0]        det_s5
);

	localparam int PW = 2 * ELEM_WIDTH;
	localparam int CW = 2 * ELEM_WIDTH + 1;
	localparam int DW = 3 * ELEM_WIDTH + 1;
	localparam int NP = 2 * N_ELEM;

	// Operand pairs: cofactor k is p[2k] - p[2k+1].
	localparam int PA [NP] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 6, 0, 0, 1};
	localparam int PB [NP] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 1, 7, 4, 3};

	logic signed [PW-1:0]         p_s2 [NP];
	logic signed [ELEM_WIDTH-1:0] a_s2 [N_ELEM];
	logic signed [ELEM_WIDTH-1:0] a_s3 [N_ELEM];
	logic signed [ELEM_WIDTH-1:0] a_s4 [N_ELEM];
	logic signed [CW-1:0]         co_s3 [N_ELEM];
	logic signed [CW-1:0]         co_s4 [N_ELEM];
	logic signed [DW-1:0]         t_s4 [3];

	// Pairwise products, cofactor differences, first-row expansion, determinant sum.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NP; i++) begin
				p_s2[i] <= a_s1[PA[i]] * a_s1[PB[i]];
			end
			for (int i = 0; i < N_ELEM; i++) begin
				co_s3[i] <= CW'(p_s2[2*i]) - CW'(p_s2[2*i+1]);
				a_s2[i] <= a_s1[i];
				a_s3[i] <= a_s2[i];
				a_s4[i] <= a_s3[i];
				a_s5[i] <= a_s4[i];
				co_s4[i] <= co_s3[i];
				co_s5[i] <= co_s4[i];
			end
			for (int j = 0; j < 3; j++) begin
				t_s4[j] <= DW'(a_s3[j]) * DW'(co_s3[3*j]);
			end
			det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/minv_div_stage.sv
// One register stage of the restoring divider: overflow check or one quotient bit.
// Depends on minv_pkg; nine lanes share one divisor.
`default_nettype none

module minv_div_stage import minv_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_W_DEF,
	parameter int BIT_POS = 0,
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [4*ELEM_WIDTH+1:0]       rem_i [N_ELEM],
	input  logic [ELEM_WIDTH:0]           quo_i [N_ELEM],
	input  logic [N_ELEM-1:0]             sat_i,
	input  logic [3*ELEM_WIDTH:0]         den_i,
	input  logic [SIDE_W-1:0]             side_i,
	output logic [4*ELEM_WIDTH+1:0]       rem_o [N_ELEM],
	output logic [ELEM_WIDTH:0]           quo_o [N_ELEM],
	output logic [N_ELEM-1:0]             sat_o,
	output logic [3*ELEM_WIDTH:0]         den_o,
	output logic [SIDE_W-1:0]             side_o
);

	localparam int WN = 4 * ELEM_WIDTH + 2;
	localparam int QW = ELEM_WIDTH + 1;

	logic [WN-1:0]     dsh;
	logic [N_ELEM-1:0] ge;
	logic [WN-1:0]     rem_n [N_ELEM];
	logic [QW-1:0]     quo_n [N_ELEM];
	logic [N_ELEM-1:0] sat_n;

	// Compare each partial remainder with the shifted divisor.
	always_comb begin
		dsh = WN'(den_i) << BIT_POS;
		for (int i = 0; i < N_ELEM; i++) begin
			ge[i] = (rem_i[i] >= dsh);
		end
	end

	generate
		if (BIT_POS == QW) begin : g_ovf
			// Top stage: a quotient needing more than QW bits saturates.
			always_comb begin
				for (int i = 0; i < N_ELEM; i++) begin
					rem_n[i] = rem_i[i];
					quo_n[i] = quo_i[i];
				end
				sat_n = sat_i | ge;
			end
		end else begin : g_bit
			// Restoring step for one quotient bit.
			always_comb begin
				for (int i = 0; i < N_ELEM; i++) begin
					rem_n[i] = ge[i] ? (rem_i[i] - dsh) : rem_i[i];
					quo_n[i] = quo_i[i];
					quo_n[i][BIT_POS] = ge[i];
				end
				sat_n = sat_i;
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= rem_n;
			quo_o <= quo_n;
			sat_o <= sat_n;
			den_o <= den_i;
			side_o <= side_i;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/minv_out.sv
// Output stage: sign, saturation, singular pass-through and result register.
// Depends on minv_pkg.
`default_nettype none

module minv_out import minv_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_W_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ELEM_WIDTH:0]           quo [N_ELEM],
	input  logic [N_ELEM-1:0]             sat,
	input  logic [N_ELEM-1:0]             neg,
	input  logic                          sing,
	input  logic signed [3*ELEM_WIDTH:0]  det,
	input  logic signed [ELEM_WIDTH-1:0]  a [N_ELEM],
	output logic [FIELD_W-1:0]            r_q [N_ELEM],
	output logic                          singular_q,
	output logic                          clipped_q,
	output logic [DET_OUT_W-1:0]          det_q
);

	localparam int QW = ELEM_WIDTH + 1;
	localparam logic [QW-1:0] BNEG = QW'(1) << (ELEM_WIDTH - 1);
	localparam logic [QW-1:0] BPOS = BNEG - QW'(1);

	logic [QW-1:0]      bound [N_ELEM];
	logic [QW-1:0]      mag_v [N_ELEM];
	logic [QW-1:0]      sval [N_ELEM];
	logic [N_ELEM-1:0]  over;
	logic [FIELD_W-1:0] r_n [N_ELEM];

	// Clamp each quotient to the signed element range, then apply the sign.
	always_comb begin
		for (int i = 0; i < N_ELEM; i++) begin
			bound[i] = neg[i] ? BNEG : BPOS;
			over[i] = sat[i] | (quo[i] > bound[i]);
			mag_v[i] = over[i] ? bound[i] : quo[i];
			sval[i] = neg[i] ? ((~mag_v[i]) + QW'(1)) : mag_v[i];
			if (sing) begin
				r_n[i] = FIELD_W'(a[i]);
			end else begin
				r_n[i] = FIELD_W'(signed'(sval[i][ELEM_WIDTH-1:0]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= r_n;
			singular_q <= sing;
			clipped_q <= ~sing & (|over);
			det_q <= DET_OUT_W'(det);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/matrix3x3_inverse.sv
// Top level of the pipelined 3x3 matrix inverse (adjugate over determinant).
// Depends on minv_pkg, minv_adj, minv_div_stage and minv_out.
`default_nettype none

// One matrix is accepted per clock cycle while the output is not stalled, and
// its result passes through one input register, four stages of products and
// cofactors, one magnitude stage, ELEM_WIDTH + 2 restoring divider stages (one
// overflow check, then one quotient bit each, nine lanes sharing the
// determinant as divisor) and the output register. The divider chain sets the
// latency. The whole pipeline advances together; when the result is not taken,
// s_tready drops and every stage holds.
module matrix3x3_inverse import minv_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_W_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// a00, a01, a02, a10, a11, a12, a20, a21, a22 (16 bits each)
	input  logic [IN_DATA_W-1:0]   s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each), det_value (49), zero pad
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// singular, clipped
	output logic [USER_W-1:0]      m_tuser
);

	localparam int E = ELEM_WIDTH;
	localparam int CW = 2 * E + 1;
	localparam int DW = 3 * E + 1;
	localparam int WN = 4 * E + 2;
	localparam int QW = E + 1;
	localparam int FRAC = E - 4;
	localparam int NDIV = QW + 1;
	localparam int SIDE_W = DW + 1 + N_ELEM + N_ELEM * E;
	localparam int PIPE_L = NDIV + 7;

	logic                 en;
	logic [PIPE_L-1:0]    valid_q;
	logic signed [E-1:0]  a_s1 [N_ELEM];
	logic signed [E-1:0]  a_s5 [N_ELEM];
	logic signed [CW-1:0] co_s5 [N_ELEM];
	logic signed [DW-1:0] det_s5;
	logic [WN-1:0]        rem_s6 [N_ELEM];
	logic [N_ELEM-1:0]    neg_s6;
	logic [DW-1:0]        den_s6;
	logic signed [DW-1:0] det_s6;
	logic                 sing_s6;
	logic signed [E-1:0]  a_s6 [N_ELEM];
	logic [N_ELEM*E-1:0]  a_flat;
	logic [WN-1:0]        rem_c [NDIV+1][N_ELEM];
	logic [QW-1:0]        quo_c [NDIV+1][N_ELEM];
	logic [N_ELEM-1:0]    sat_c [NDIV+1];
	logic [DW-1:0]        den_c [NDIV+1];
	logic [SIDE_W-1:0]    side_c [NDIV+1];
	logic signed [E-1:0]  a_end [N_ELEM];
	logic [FIELD_W-1:0]   r_q [N_ELEM];
	logic                 singular_q;
	logic                 clipped_q;
	logic [DET_OUT_W-1:0] det_q;

	// Pipeline advances whenever the output register is free or being drained.
	assign en = ~valid_q[PIPE_L-1] | m_tready;
	assign s_tready = en;
	assign m_tvalid = valid_q[PIPE_L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[PIPE_L-2:0], s_tvalid};
		end
	end

	// Input register: low ELEM_WIDTH bits of each field.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ELEM; i++) begin
				a_s1[i] <= E'(s_tdata[i*FIELD_W +: FIELD_W]);
			end
		end
	end

	minv_adj #(.ELEM_WIDTH(E)) u_adj (
		.clk    (clk),
		.en     (en),
		.a_s1   (a_s1),
		.a_s5   (a_s5),
		.co_s5  (co_s5),
		.det_s5 (det_s5)
	);

	// Magnitudes, quotient signs and scaled dividends.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ELEM; i++) begin
				rem_s6[i] <= WN'(co_s5[i][CW-1] ? (~co_s5[i] + CW'(1)) : co_s5[i]) << (2 * FRAC);
				neg_s6[i] <= co_s5[i][CW-1] ^ det_s5[DW-1];
				a_s6[i] <= a_s5[i];
			end
			den_s6 <= det_s5[DW-1] ? (~det_s5 + DW'(1)) : det_s5;
			det_s6 <= det_s5;
			sing_s6 <= (det_s5 == '0);
		end
	end

	// Divider chain head.
	always_comb begin
		for (int i = 0; i < N_ELEM; i++) begin
			a_flat[i*E +: E] = a_s6[i];
			rem_c[0][i] = rem_s6[i];
			quo_c[0][i] = '0;
		end
		sat_c[0] = '0;
		den_c[0] = den_s6;
		side_c[0] = {det_s6, sing_s6, neg_s6, a_flat};
	end

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		minv_div_stage #(
			.ELEM_WIDTH (E),
			.BIT_POS    (QW - g),
			.SIDE_W     (SIDE_W)
		) u_stage (
			.clk    (clk),
			.en     (en),
			.rem_i  (rem_c[g]),
			.quo_i  (quo_c[g]),
			.sat_i  (sat_c[g]),
			.den_i  (den_c[g]),
			.side_i (side_c[g]),
			.rem_o  (rem_c[g+1]),
			.quo_o  (quo_c[g+1]),
			.sat_o  (sat_c[g+1]),
			.den_o  (den_c[g+1]),
			.side_o (side_c[g+1])
		);
	end

	// Unpack the original elements carried beside the divider.
	always_comb begin
		for (int i = 0; i < N_ELEM; i++) begin
			a_end[i] = side_c[NDIV][i*E +: E];
		end
	end

	minv_out #(.ELEM_WIDTH(E)) u_out (
		.clk        (clk),
		.en         (en),
		.quo        (quo_c[NDIV]),
		.sat        (sat_c[NDIV]),
		.neg        (side_c[NDIV][N_ELEM*E +: N_ELEM]),
		.sing       (side_c[NDIV][N_ELEM*E+N_ELEM]),
		.det        (side_c[NDIV][SIDE_W-1 -: DW]),
		.a          (a_end),
		.r_q        (r_q),
		.singular_q (singular_q),
		.clipped_q  (clipped_q),
		.det_q      (det_q)
	);

	// Result bus packing.
	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < N_ELEM; i++) begin
			m_tdata[i*FIELD_W +: FIELD_W] = r_q[i];
		end
		m_tdata[N_ELEM*FIELD_W +: DET_OUT_W] = det_q;
		m_tuser = '0;
		m_tuser[USER_SINGULAR] = singular_q;
		m_tuser[USER_CLIPPED] = clipped_q;
	end

endmodule

`default_nettype wire

FILE: rtl/minv_check.sv
// Port-level checker for the matrix inverse, bound to the top level.
// Depends on minv_pkg and matrix3x3_inverse_assert.svh.
`default_nettype none

`include "matrix3x3_inverse_assert.svh"

module minv_check import minv_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic [IN_DATA_W-1:0]  s_tdata,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [USER_W-1:0]     m_tuser
);

	// A held result blocks new input transfers.
	`MINV_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
	// A singular matrix never reports saturation and carries a zero determinant.
	`MINV_ASSERT_NOW(a_singular_clean, m_tvalid && m_tuser[USER_SINGULAR], !m_tuser[USER_CLIPPED] && m_tdata[N_ELEM*FIELD_W +: DET_OUT_W] == '0)
	// An invertible matrix has a nonzero determinant.
	`MINV_ASSERT_NOW(a_regular_det, m_tvalid && !m_tuser[USER_SINGULAR], m_tdata[N_ELEM*FIELD_W +: DET_OUT_W] != '0)
	// A stalled result stays in place.
	`MINV_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Unused here beyond the handshake view.
	logic unused_in;
	assign unused_in = s_tvalid ^ (^s_tdata);

endmodule

bind matrix3x3_inverse minv_check u_minv_check (.*);

`default_nettype wire
